>>> hw/rtl/sfq_pkg.sv
// Shared types, constants and helper functions of the surface force quadrature block.
// No dependencies; every other file in hw/rtl imports this package.
package sfq_pkg;

	localparam int unsigned MAX_ORDER = 6;

	localparam logic [1:0] CFG_GAS_RT     = 2'd0;
	localparam logic [1:0] CFG_POLY_ORDER = 2'd1;

	localparam logic [1:0] SH_0  = 2'd0;
	localparam logic [1:0] SH_14 = 2'd1;
	localparam logic [1:0] SH_16 = 2'd2;
	localparam logic [1:0] SH_30 = 2'd3;

	localparam logic signed [33:0] SQRT2_Q30 = 34'sd1518500250;

	localparam logic signed [49:0] POS48 = 50'sh0_7FFF_FFFF_FFFF;
	localparam logic signed [49:0] NEG48 = -50'sh0_8000_0000_0000;

	localparam logic [30:0] LOBATTO_W [8][8] = '{
		'{31'd0, 31'd0, 31'd0, 31'd0, 31'd0, 31'd0, 31'd0, 31'd0},
		'{31'd1073741824, 31'd1073741824, 31'd0, 31'd0, 31'd0, 31'd0, 31'd0, 31'd0},
		'{31'd357913941, 31'd1431655765, 31'd357913941, 31'd0, 31'd0, 31'd0, 31'd0,
			31'd0},
		'{31'd178956971, 31'd894784853, 31'd894784853, 31'd178956971, 31'd0, 31'd0,
			31'd0, 31'd0},
		'{31'd107374182, 31'd584592771, 31'd763549742, 31'd584592771, 31'd107374182,
			31'd0, 31'd0, 31'd0},
		'{31'd71582788, 31'd406384390, 31'd595774646, 31'd595774646, 31'd406384390,
			31'd71582788, 31'd0, 31'd0},
		'{31'd51130563, 31'd297239705, 31'd463583073, 31'd523576966, 31'd463583073,
			31'd297239705, 31'd51130563, 31'd0},
		'{31'd0, 31'd0, 31'd0, 31'd0, 31'd0, 31'd0, 31'd0, 31'd0}
	};

	typedef struct packed {
		logic signed [31:0] density;
		logic signed [31:0] momentum_x;
		logic signed [31:0] momentum_y;
		logic signed [31:0] moment_xy;
		logic signed [31:0] moment_xx;
		logic signed [31:0] moment_yy;
		logic signed [15:0] normal_x;
		logic signed [15:0] normal_y;
		logic [31:0]        surface_jacobian;
		logic [2:0]         node_index;
		logic               last_node;
	} node_t;

	typedef struct packed {
		logic signed [47:0] force_x;
		logic signed [47:0] force_y;
		logic               zero_density_seen;
		logic               saturated;
	} result_t;

	typedef struct packed {
		node_t       nd;
		logic [30:0] weight;
		logic        zero_density;
	} work_t;

	function automatic logic signed [47:0] sat48_f(input logic signed [49:0] v);
		logic signed [47:0] r;
		if (v > POS48) begin
			r = POS48[47:0];
		end else if (v < NEG48) begin
			r = NEG48[47:0];
		end else begin
			r = v[47:0];
		end
		return r;
	endfunction

	function automatic logic ovf48_f(input logic signed [49:0] v);
		return (v > POS48) || (v < NEG48);
	endfunction

endpackage

>>> hw/rtl/sfq_front.sv
// Front end: accepts node transactions, looks up the quadrature weight and flags
// zero density, then holds the classified work in a short queue. Uses sfq_pkg.
module sfq_front #(
	parameter int DEPTH = 4
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           node_valid,
	output logic           node_stall,
	input  sfq_pkg::node_t node,
	input  logic [2:0]     poly_order,
	output logic           avail,
	output sfq_pkg::work_t head,
	input  logic           pop
);
	import sfq_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	work_t             mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic              full;
	logic              push;
	logic              take;
	logic              order_ok;
	work_t             entry;

	assign full       = (count_q == CNT_W'(DEPTH));
	assign node_stall = full;
	assign push       = node_valid && !full;
	assign avail      = (count_q != '0);
	assign take       = pop && avail;
	assign head       = mem_q[rd_ptr_q];

	assign order_ok = (poly_order >= 3'd1) && (32'(poly_order) <= MAX_ORDER)
		&& (node.node_index <= poly_order);

	always_comb begin
		entry.nd           = node;
		entry.weight       = order_ok ? LOBATTO_W[poly_order][node.node_index] : '0;
		entry.zero_density = (node.density == '0);
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (take) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !take) begin
				count_q <= count_q + 1'b1;
			end else if (take && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

>>> hw/rtl/sfq_mul.sv
// Sequential signed multiplier with round-half-away shift and 48-bit saturation.
// Three 16-bit partial products, then a finishing step that saturates and registers the result. Uses sfq_pkg.
module sfq_mul (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [48:0] a,
	input  logic signed [33:0] b,
	input  logic [1:0]         sh,
	output logic               done,
	output logic signed [47:0] res,
	output logic               sat,
	output logic [62:0]        mag,
	output logic               neg
);
	import sfq_pkg::*;

	logic [47:0]        ma_q;
	logic [33:0]        mb_q;
	logic               neg_q;
	logic [1:0]         sh_q;
	logic [81:0]        acc_q;
	logic [1:0]         cnt_q;
	logic               run_q;
	logic               fin_q;
	logic               done_q;
	logic signed [47:0] res_q;
	logic               sat_q;
	logic [62:0]        mag_q;
	logic [48:0]        abs_a;
	logic [33:0]        abs_b;
	logic [81:0]        half;
	logic [15:0]        chunk;
	logic [49:0]        prod;
	logic [81:0]        part;
	logic [81:0]        shifted;
	logic [81:0]        lim;
	logic               ovf;
	logic [47:0]        mag48;

	assign abs_a = a[48] ? 49'(-a) : 49'(a);
	assign abs_b = b[33] ? 34'(-b) : 34'(b);

	always_comb begin
		unique case (sh)
			SH_0:    half = '0;
			SH_14:   half = 82'(1) << 13;
			SH_16:   half = 82'(1) << 15;
			SH_30:   half = 82'(1) << 29;
			default: half = '0;
		endcase
	end

	always_comb begin
		unique case (cnt_q)
			2'd0:    chunk = ma_q[15:0];
			2'd1:    chunk = ma_q[31:16];
			2'd2:    chunk = ma_q[47:32];
			default: chunk = '0;
		endcase
	end

	assign prod = 50'(chunk) * 50'(mb_q);

	always_comb begin
		unique case (cnt_q)
			2'd0:    part = {32'd0, prod};
			2'd1:    part = {16'd0, prod, 16'd0};
			2'd2:    part = {prod, 32'd0};
			default: part = '0;
		endcase
	end

	always_comb begin
		unique case (sh_q)
			SH_0:    shifted = acc_q;
			SH_14:   shifted = acc_q >> 14;
			SH_16:   shifted = acc_q >> 16;
			SH_30:   shifted = acc_q >> 30;
			default: shifted = acc_q;
		endcase
	end

	assign lim   = neg_q ? 82'h8000_0000_0000 : 82'h7FFF_FFFF_FFFF;
	assign ovf   = shifted > lim;
	assign mag48 = ovf ? lim[47:0] : shifted[47:0];

	always_ff @(posedge clk) begin
		if (start) begin
			ma_q  <= abs_a[47:0];
			mb_q  <= abs_b;
			neg_q <= a[48] ^ b[33];
			sh_q  <= sh;
			acc_q <= half;
		end else if (run_q) begin
			acc_q <= acc_q + part;
		end
		if (fin_q) begin
			res_q <= neg_q ? 48'(-mag48) : mag48;
			sat_q <= ovf;
			mag_q <= shifted[62:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= fin_q;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == 2'd2) begin
					run_q <= 1'b0;
					fin_q <= 1'b1;
				end
			end else if (fin_q) begin
				fin_q <= 1'b0;
			end
		end
	end

	assign done = done_q;
	assign res  = res_q;
	assign sat  = sat_q;
	assign mag  = mag_q;
	assign neg  = neg_q;

endmodule

>>> hw/rtl/sfq_div.sv
// Restoring divider, one quotient bit per cycle, truncating toward zero,
// with 48-bit signed saturation of the quotient. Uses sfq_pkg.
module sfq_div (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [62:0]        num,
	input  logic [31:0]        den,
	input  logic               neg,
	output logic               done,
	output logic signed [47:0] res,
	output logic               sat
);
	import sfq_pkg::*;

	logic [62:0]        nq_q;
	logic [31:0]        rem_q;
	logic [31:0]        den_q;
	logic               neg_q;
	logic [5:0]         cnt_q;
	logic               run_q;
	logic               fin_q;
	logic               done_q;
	logic signed [47:0] res_q;
	logic               sat_q;
	logic [32:0]        trial;
	logic [32:0]        diff;
	logic               ge;
	logic [62:0]        lim;
	logic               ovf;
	logic [47:0]        mag48;

	assign trial = {rem_q, nq_q[62]};
	assign ge    = trial >= {1'b0, den_q};
	assign diff  = trial - {1'b0, den_q};
	assign lim   = neg_q ? 63'h8000_0000_0000 : 63'h7FFF_FFFF_FFFF;
	assign ovf   = nq_q > lim;
	assign mag48 = ovf ? lim[47:0] : nq_q[47:0];

	always_ff @(posedge clk) begin
		if (start) begin
			nq_q  <= num;
			rem_q <= '0;
			den_q <= den;
			neg_q <= neg;
		end else if (run_q) begin
			rem_q <= ge ? diff[31:0] : trial[31:0];
			nq_q  <= {nq_q[61:0], ge};
		end
		if (fin_q) begin
			res_q <= neg_q ? 48'(-mag48) : mag48;
			sat_q <= ovf;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= fin_q;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == 6'd62) begin
					run_q <= 1'b0;
					fin_q <= 1'b1;
				end
			end else if (fin_q) begin
				fin_q <= 1'b0;
			end
		end
	end

	assign done = done_q;
	assign res  = res_q;
	assign sat  = sat_q;

endmodule

>>> hw/rtl/sfq_back.sv
// Back end: sequences one node's stress, pressure and weight terms through the
// shared multiplier and divider, accumulates the forces and holds the result.
// Uses sfq_pkg, sfq_mul, sfq_div.
module sfq_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [31:0]      gas_rt,
	input  logic             avail,
	input  sfq_pkg::work_t   head,
	output logic             pop,
	output logic             result_valid,
	input  logic             result_stall,
	output sfq_pkg::result_t result
);
	import sfq_pkg::*;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_ISSUE = 3'd1;
	localparam logic [2:0] ST_MWAIT = 3'd2;
	localparam logic [2:0] ST_DWAIT = 3'd3;
	localparam logic [2:0] ST_FIN   = 3'd4;

	localparam logic [3:0] OP_P11 = 4'd0;
	localparam logic [3:0] OP_P12 = 4'd1;
	localparam logic [3:0] OP_P22 = 4'd2;
	localparam logic [3:0] OP_A11 = 4'd3;
	localparam logic [3:0] OP_A22 = 4'd4;
	localparam logic [3:0] OP_S11 = 4'd5;
	localparam logic [3:0] OP_S12 = 4'd6;
	localparam logic [3:0] OP_S22 = 4'd7;
	localparam logic [3:0] OP_PR  = 4'd8;
	localparam logic [3:0] OP_X1  = 4'd9;
	localparam logic [3:0] OP_X2  = 4'd10;
	localparam logic [3:0] OP_Y1  = 4'd11;
	localparam logic [3:0] OP_Y2  = 4'd12;
	localparam logic [3:0] OP_CW  = 4'd13;
	localparam logic [3:0] OP_FX  = 4'd14;
	localparam logic [3:0] OP_FY  = 4'd15;

	logic [2:0]         state_q;
	logic [3:0]         step_q;
	work_t              item_q;
	logic signed [47:0] t11_q, t12_q, t22_q, a11_q, a22_q;
	logic signed [47:0] s11_q, s12_q, s22_q, p_q;
	logic signed [47:0] x1_q, x2_q, y1_q, y2_q, c_q;
	logic signed [47:0] sum_x_q, sum_y_q;
	logic               zero_q;
	logic               sat_q;
	logic               res_valid_q;
	result_t            res_q;

	logic signed [49:0] pre;
	logic signed [47:0] pre_s;
	logic               pre_ovf;
	logic signed [48:0] pre_neg;
	logic signed [48:0] op_a;
	logic signed [33:0] op_b;
	logic [1:0]         op_sh;
	logic               mul_start;
	logic               mul_done;
	logic signed [47:0] mul_res;
	logic               mul_sat;
	logic [62:0]        mul_mag;
	logic               mul_neg;
	logic               div_start;
	logic               div_done;
	logic signed [47:0] div_res;
	logic               div_sat;
	logic [31:0]        rho_abs;
	logic signed [49:0] acc_sum;
	logic signed [47:0] acc_s;
	logic               acc_ovf;
	logic               can_load;
	logic               load_res;
	logic signed [33:0] rt_b;

	assign rt_b    = $signed({2'b00, gas_rt});
	assign rho_abs = item_q.nd.density[31] ? 32'd0 - item_q.nd.density : item_q.nd.density;

	always_comb begin
		pre = '0;
		unique case (step_q)
			OP_S11: pre = 50'(a11_q) - 50'(t11_q);
			OP_S12: pre = 50'($signed(item_q.nd.moment_xy)) - 50'(t12_q);
			OP_S22: pre = 50'(a22_q) - 50'(t22_q);
			OP_X1:  pre = 50'(s11_q) - 50'(p_q);
			OP_Y2:  pre = 50'(s22_q) - 50'(p_q);
			OP_FX:  pre = 50'(x1_q) + 50'(x2_q);
			OP_FY:  pre = 50'(y1_q) + 50'(y2_q);
			default: pre = '0;
		endcase
	end

	assign pre_s   = sat48_f(pre);
	assign pre_ovf = ovf48_f(pre);
	assign pre_neg = -(49'(pre_s));

	always_comb begin
		op_a  = '0;
		op_b  = '0;
		op_sh = SH_0;
		unique case (step_q)
			OP_P11: begin
				op_a = 49'($signed(item_q.nd.momentum_x));
				op_b = 34'($signed(item_q.nd.momentum_x));
			end
			OP_P12: begin
				op_a = 49'($signed(item_q.nd.momentum_x));
				op_b = 34'($signed(item_q.nd.momentum_y));
			end
			OP_P22: begin
				op_a = 49'($signed(item_q.nd.momentum_y));
				op_b = 34'($signed(item_q.nd.momentum_y));
			end
			OP_A11: begin
				op_a  = 49'($signed(item_q.nd.moment_xx));
				op_b  = SQRT2_Q30;
				op_sh = SH_30;
			end
			OP_A22: begin
				op_a  = 49'($signed(item_q.nd.moment_yy));
				op_b  = SQRT2_Q30;
				op_sh = SH_30;
			end
			OP_S11, OP_S12, OP_S22: begin
				op_a  = pre_neg;
				op_b  = rt_b;
				op_sh = SH_16;
			end
			OP_PR: begin
				op_a  = 49'($signed(item_q.nd.density));
				op_b  = rt_b;
				op_sh = SH_16;
			end
			OP_X1: begin
				op_a  = 49'(pre_s);
				op_b  = 34'($signed(item_q.nd.normal_x));
				op_sh = SH_14;
			end
			OP_X2: begin
				op_a  = 49'(s12_q);
				op_b  = 34'($signed(item_q.nd.normal_y));
				op_sh = SH_14;
			end
			OP_Y1: begin
				op_a  = 49'(s12_q);
				op_b  = 34'($signed(item_q.nd.normal_x));
				op_sh = SH_14;
			end
			OP_Y2: begin
				op_a  = 49'(pre_s);
				op_b  = 34'($signed(item_q.nd.normal_y));
				op_sh = SH_14;
			end
			OP_CW: begin
				op_a  = $signed({17'd0, item_q.nd.surface_jacobian});
				op_b  = $signed({3'b000, item_q.weight});
				op_sh = SH_30;
			end
			OP_FX, OP_FY: begin
				op_a  = 49'(pre_s);
				op_b  = c_q[33:0];
				op_sh = SH_16;
			end
			default: begin
				op_a = '0;
			end
		endcase
	end

	assign mul_start = (state_q == ST_ISSUE);
	assign div_start = (state_q == ST_MWAIT) && mul_done && (step_q <= OP_P22);

	sfq_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (op_a),
		.b      (op_b),
		.sh     (op_sh),
		.done   (mul_done),
		.res    (mul_res),
		.sat    (mul_sat),
		.mag    (mul_mag),
		.neg    (mul_neg)
	);

	sfq_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (mul_mag),
		.den    (rho_abs),
		.neg    (mul_neg ^ item_q.nd.density[31]),
		.done   (div_done),
		.res    (div_res),
		.sat    (div_sat)
	);

	assign acc_sum  = (step_q == OP_FX) ? 50'(sum_x_q) + 50'(mul_res)
		: 50'(sum_y_q) + 50'(mul_res);
	assign acc_s    = sat48_f(acc_sum);
	assign acc_ovf  = ovf48_f(acc_sum);
	assign pop      = (state_q == ST_IDLE) && avail;
	assign can_load = !res_valid_q || !result_stall;
	assign load_res = (state_q == ST_FIN) && item_q.nd.last_node && can_load;

	always_ff @(posedge clk) begin
		if (pop) begin
			item_q <= head;
		end
		if (state_q == ST_DWAIT && div_done) begin
			unique case (step_q)
				OP_P11:  t11_q <= div_res;
				OP_P12:  t12_q <= div_res;
				default: t22_q <= div_res;
			endcase
		end
		if (state_q == ST_MWAIT && mul_done) begin
			unique case (step_q)
				OP_A11: a11_q <= mul_res;
				OP_A22: a22_q <= mul_res;
				OP_S11: s11_q <= mul_res;
				OP_S12: s12_q <= mul_res;
				OP_S22: s22_q <= mul_res;
				OP_PR:  p_q   <= mul_res;
				OP_X1:  x1_q  <= mul_res;
				OP_X2:  x2_q  <= mul_res;
				OP_Y1:  y1_q  <= mul_res;
				OP_Y2:  y2_q  <= mul_res;
				OP_CW:  c_q   <= mul_res;
				default: begin
				end
			endcase
		end
		if (load_res) begin
			res_q.force_x           <= sum_x_q;
			res_q.force_y           <= sum_y_q;
			res_q.zero_density_seen <= zero_q;
			res_q.saturated         <= sat_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= OP_P11;
			sum_x_q     <= '0;
			sum_y_q     <= '0;
			zero_q      <= 1'b0;
			sat_q       <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (load_res) begin
				res_valid_q <= 1'b1;
			end else if (res_valid_q && !result_stall) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (avail) begin
						step_q <= OP_P11;
						if (head.zero_density) begin
							zero_q  <= 1'b1;
							state_q <= ST_FIN;
						end else begin
							state_q <= ST_ISSUE;
						end
					end
				end
				ST_ISSUE: begin
					sat_q   <= sat_q | pre_ovf;
					state_q <= ST_MWAIT;
				end
				ST_MWAIT: begin
					if (mul_done) begin
						if (step_q <= OP_P22) begin
							state_q <= ST_DWAIT;
						end else begin
							if (step_q == OP_FX) begin
								sum_x_q <= acc_s;
								sat_q   <= sat_q | mul_sat | acc_ovf;
							end else if (step_q == OP_FY) begin
								sum_y_q <= acc_s;
								sat_q   <= sat_q | mul_sat | acc_ovf;
							end else begin
								sat_q <= sat_q | mul_sat;
							end
							if (step_q == OP_FY) begin
								state_q <= ST_FIN;
							end else begin
								step_q  <= step_q + 1'b1;
								state_q <= ST_ISSUE;
							end
						end
					end
				end
				ST_DWAIT: begin
					if (div_done) begin
						sat_q   <= sat_q | div_sat;
						step_q  <= step_q + 1'b1;
						state_q <= ST_ISSUE;
					end
				end
				ST_FIN: begin
					if (!item_q.nd.last_node) begin
						state_q <= ST_IDLE;
					end else if (can_load) begin
						sum_x_q <= '0;
						sum_y_q <= '0;
						zero_q  <= 1'b0;
						sat_q   <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign result_valid = res_valid_q;
	assign result       = res_q;

endmodule

>>> hw/rtl/surface_force_quadrature_unit.sv
// Surface force quadrature unit: top level with configuration registers.
// Each node runs 16 multiplies on the shared 16x34 multiplier and 3 divisions on the
// bit-serial divider; a zero-density node skips them. One node is in the back end at
// a time, so the back end takes a new node only when it is through with the last one;
// the queue buffers more.
// Reset clears sums, flags, queue and result_valid; gas_rt resets to 1.0, poly_order to 1.
// Uses sfq_pkg, sfq_front, sfq_back.
module surface_force_quadrature_unit #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             node_valid,
	output logic             node_stall,
	input  sfq_pkg::node_t   node,
	output logic             result_valid,
	input  logic             result_stall,
	output sfq_pkg::result_t result,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [1:0]       cfg_index,
	input  logic [31:0]      cfg_data
);
	import sfq_pkg::*;

	logic [31:0] gas_rt_q;
	logic [2:0]  poly_order_q;
	logic        avail;
	logic        pop;
	work_t       head;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gas_rt_q     <= 32'd65536;
			poly_order_q <= 3'd1;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_GAS_RT:     gas_rt_q     <= cfg_data;
				CFG_POLY_ORDER: poly_order_q <= cfg_data[2:0];
				default: begin
				end
			endcase
		end
	end

	sfq_front #(
		.DEPTH (QUEUE_DEPTH)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.node_valid (node_valid),
		.node_stall (node_stall),
		.node       (node),
		.poly_order (poly_order_q),
		.avail      (avail),
		.head       (head),
		.pop        (pop)
	);

	sfq_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.gas_rt       (gas_rt_q),
		.avail        (avail),
		.head         (head),
		.pop          (pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule
